@@ rtl/core/brq_pkg.sv @@
`default_nettype none

package brq_pkg;

  // ring geometry and entry sizes
  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned MAX_READERS  = 32;
  localparam int unsigned PAYLOAD_BITS = 32;

  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(MAX_READERS + 1);
  localparam int unsigned STORE_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  localparam logic [SLOT_W:0] DEPTH_WRAP = (SLOT_W + 1)'(DEPTH);

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_CONSUMER_COUNT = '0;

  typedef enum logic {
    CMD_EMIT    = 1'b0,
    CMD_CONSUME = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DROPPED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_EVAL,
    S_READ,
    S_PRUNE_RD,
    S_PRUNE_CHK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/brq_ram.sv @@
`default_nettype none

module brq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/broadcast_ring_queue_top.sv @@
`default_nettype none

// channel   direction  handshake           fields
// in_       input      in_valid/in_stall   command, payload, read_index
// out_      output     out_valid/out_stall status, data, oldest_index, write_index
// cfg       input      apb (psel..pready)  consumer_count at byte address 0
//
// emit, refused emit and refused consume: calc, eval, then done registers the result
// good consume: calc, eval, read, then prune read and check per retired head entry,
//   no check once the ring drains empty; the count ram's single read port walks the head
// reset: synchronous on rst_n low; clears indices, consumer count and valid
// the ring rams are not cleared; only live entries are ever read
// a result waits in the output register, so the next item can be taken meanwhile;
//   a held result keeps the sequencer in its last cycle until it is taken

module broadcast_ring_queue_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [31:0]                   in_payload,
  input  wire logic [31:0]                   in_read_index,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [2:0]                    out_status,
  output logic      [31:0]                   out_data,
  output logic      [31:0]                   out_oldest_index,
  output logic      [31:0]                   out_write_index,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [brq_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  // sequencer and index state
  brq_pkg::state_t             state_r, state_nxt;
  logic [31:0]                 head_r, head_nxt;
  logic [31:0]                 tail_r, tail_nxt;
  logic [brq_pkg::SLOT_W-1:0]  head_slot_r, head_slot_nxt;
  logic [5:0]                  cons_r;

  // captured item and working values
  brq_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [brq_pkg::STORE_W-1:0] pay_r, pay_nxt;
  logic [31:0]                 ridx_r, ridx_nxt;
  logic [31:0]                 live_r, live_nxt;
  logic [31:0]                 off_r, off_nxt;
  logic                        at_tail_r, at_tail_nxt;
  logic [brq_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  brq_pkg::status_t            status_r, status_nxt;
  logic [31:0]                 data_r, data_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  brq_pkg::status_t            out_status_r, out_status_nxt;
  logic [31:0]                 out_data_r, out_data_nxt;
  logic [31:0]                 out_oldest_r, out_oldest_nxt;
  logic [31:0]                 out_write_r, out_write_nxt;

  // ram ports
  logic                        pay_we;
  logic [brq_pkg::SLOT_W-1:0]  pay_raddr;
  logic [brq_pkg::STORE_W-1:0] pay_rdata;
  logic                        cnt_we;
  logic [brq_pkg::CNT_W-1:0]   cnt_wdata;
  logic [brq_pkg::SLOT_W-1:0]  cnt_waddr;
  logic [brq_pkg::SLOT_W-1:0]  cnt_raddr;
  logic [brq_pkg::CNT_W-1:0]   cnt_rdata;

  // shared slot adder: head slot plus an offset, wrapped at the ring depth
  logic [brq_pkg::SLOT_W-1:0]  ofs;
  logic [brq_pkg::SLOT_W:0]    slot_sum;
  logic [brq_pkg::SLOT_W-1:0]  slot_calc;
  logic [brq_pkg::SLOT_W:0]    head_inc;
  logic [brq_pkg::SLOT_W-1:0]  head_slot_inc;
  logic [brq_pkg::CNT_W-1:0]   cnt_init;
  logic                        cfg_wr;
  logic                        cfg_hit;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[brq_pkg::ADDR_W-1:2] == brq_pkg::REG_CONSUMER_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? 32'(cons_r) : '0;

  // clamp the reader count to MAX_READERS
  assign cnt_init = ({26'd0, cons_r} > 32'(brq_pkg::MAX_READERS))
                    ? brq_pkg::CNT_W'(brq_pkg::MAX_READERS)
                    : brq_pkg::CNT_W'(cons_r);

  // emit places at head + live, consume reads at head + offset
  assign ofs       = (cmd_r == brq_pkg::CMD_EMIT) ? live_r[brq_pkg::SLOT_W-1:0]
                                                  : off_r[brq_pkg::SLOT_W-1:0];
  assign slot_sum  = {1'b0, head_slot_r} + {1'b0, ofs};
  assign slot_calc = (slot_sum >= brq_pkg::DEPTH_WRAP)
                     ? brq_pkg::SLOT_W'(slot_sum - brq_pkg::DEPTH_WRAP)
                     : slot_sum[brq_pkg::SLOT_W-1:0];

  assign head_inc      = {1'b0, head_slot_r} + (brq_pkg::SLOT_W + 1)'(1);
  assign head_slot_inc = (head_inc >= brq_pkg::DEPTH_WRAP)
                         ? brq_pkg::SLOT_W'(head_inc - brq_pkg::DEPTH_WRAP)
                         : head_inc[brq_pkg::SLOT_W-1:0];

  brq_ram #(
    .WIDTH (brq_pkg::STORE_W),
    .DEPTH (brq_pkg::DEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (slot_calc),
    .wdata (pay_r),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  brq_ram #(
    .WIDTH (brq_pkg::CNT_W),
    .DEPTH (brq_pkg::DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    head_slot_nxt  = head_slot_r;
    cmd_nxt        = cmd_r;
    pay_nxt        = pay_r;
    ridx_nxt       = ridx_r;
    live_nxt       = live_r;
    off_nxt        = off_r;
    at_tail_nxt    = at_tail_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    data_nxt       = data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_oldest_nxt = out_oldest_r;
    out_write_nxt  = out_write_r;
    in_stall       = 1'b1;
    pay_we         = 1'b0;
    pay_raddr      = slot_calc;
    cnt_we         = 1'b0;
    cnt_waddr      = slot_calc;
    cnt_wdata      = cnt_init;
    cnt_raddr      = head_slot_r;

    unique case (state_r)
      brq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_nxt   = brq_pkg::cmd_t'(in_command);
          pay_nxt   = in_payload[brq_pkg::STORE_W-1:0];
          ridx_nxt  = in_read_index;
          state_nxt = brq_pkg::S_CALC;
        end
      end

      brq_pkg::S_CALC: begin
        live_nxt    = tail_r - head_r;
        off_nxt     = ridx_r - head_r;
        at_tail_nxt = (ridx_r == tail_r);
        state_nxt   = brq_pkg::S_EVAL;
      end

      brq_pkg::S_EVAL: begin
        data_nxt   = '0;
        status_nxt = brq_pkg::ST_OK;
        state_nxt  = brq_pkg::S_DONE;
        if (cmd_r == brq_pkg::CMD_EMIT) begin
          // fullness wins over a missing reader
          if (live_r >= 32'(brq_pkg::DEPTH)) begin
            status_nxt = brq_pkg::ST_FULL;
          end else if (cons_r == '0) begin
            status_nxt = brq_pkg::ST_DROPPED;
          end else begin
            pay_we   = 1'b1;
            cnt_we   = 1'b1;
            tail_nxt = tail_r + 32'd1;
          end
        end else begin
          if (at_tail_r) begin
            status_nxt = brq_pkg::ST_EMPTY;
          end else if ((off_r >= live_r) || (off_r >= 32'(brq_pkg::DEPTH))) begin
            status_nxt = brq_pkg::ST_BAD_IDX;
          end else begin
            slot_nxt  = slot_calc;
            cnt_raddr = slot_calc;
            state_nxt = brq_pkg::S_READ;
          end
        end
      end

      brq_pkg::S_READ: begin
        // data and count arrive from the rams; count saturates at zero
        data_nxt  = 32'(pay_rdata);
        cnt_we    = 1'b1;
        cnt_waddr = slot_r;
        cnt_wdata = (cnt_rdata == '0) ? '0 : cnt_rdata - brq_pkg::CNT_W'(1);
        state_nxt = brq_pkg::S_PRUNE_RD;
      end

      brq_pkg::S_PRUNE_RD: begin
        cnt_raddr = head_slot_r;
        if (head_r == tail_r) begin
          state_nxt = brq_pkg::S_DONE;
        end else begin
          state_nxt = brq_pkg::S_PRUNE_CHK;
        end
      end

      brq_pkg::S_PRUNE_CHK: begin
        if (cnt_rdata == '0) begin
          head_nxt      = head_r + 32'd1;
          head_slot_nxt = head_slot_inc;
          state_nxt     = brq_pkg::S_PRUNE_RD;
        end else begin
          state_nxt = brq_pkg::S_DONE;
        end
      end

      brq_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = data_r;
          out_oldest_nxt = head_r;
          out_write_nxt  = tail_r;
          state_nxt      = brq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = brq_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      head_slot_r <= '0;
      cons_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      head_slot_r <= head_slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        cons_r <= pwdata[5:0];
      end
    end
  end

  // working values and result fields
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pay_r        <= pay_nxt;
    ridx_r       <= ridx_nxt;
    live_r       <= live_nxt;
    off_r        <= off_nxt;
    at_tail_r    <= at_tail_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    data_r       <= data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_oldest_r <= out_oldest_nxt;
    out_write_r  <= out_write_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data         = out_data_r;
  assign out_oldest_index = out_oldest_r;
  assign out_write_index  = out_write_r;

  // live entries never exceed the ring depth
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r - head_r) <= 32'(brq_pkg::DEPTH))
    else $error("live count beyond ring depth");

  // head only moves by one, and only when a finished entry is retired
  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != $past(head_r)) |->
      ($past(state_r) == brq_pkg::S_PRUNE_CHK && head_r == $past(head_r) + 32'd1))
    else $error("head moved outside pruning");

  // tail only moves by one, and only on a stored emit
  a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r != $past(tail_r)) |->
      ($past(state_r) == brq_pkg::S_EVAL && tail_r == $past(tail_r) + 32'd1))
    else $error("tail moved outside an emit");

endmodule

`default_nettype wire
